FILE: rtl/core/sefc_pkg.sv
// Shared types and codes for the sprite extrusion face culler.
// Used by every module under rtl/core; depends on nothing.
`default_nettype none

package sefc_pkg;

    // item kinds
    localparam logic KIND_PIXEL = 1'b0;
    localparam logic KIND_FLUSH = 1'b1;

    // face codes, also the bit positions in a face mask
    localparam logic [2:0] FACE_TOP      = 3'd0;
    localparam logic [2:0] FACE_BOTTOM   = 3'd1;
    localparam logic [2:0] FACE_ROW_MINUS = 3'd2;
    localparam logic [2:0] FACE_ROW_PLUS  = 3'd3;
    localparam logic [2:0] FACE_COL_PLUS  = 3'd4;
    localparam logic [2:0] FACE_COL_MINUS = 3'd5;
    localparam int         FACE_COUNT     = 6;

    // register indexes
    localparam int REG_IMAGE_HEIGHT = 0;

    localparam int HEIGHT_FIELD_W = 7;
    localparam int QUEUE_DEPTH    = 2;

    typedef struct packed {
        logic       kind;
        logic [7:0] alpha;
    } pixel_item_t;

    typedef struct packed {
        logic [5:0] cell_x;
        logic [5:0] cell_y;
        logic [2:0] face;
        logic       last;
    } face_item_t;

    // one decided cell waiting for serialization
    typedef struct packed {
        logic [FACE_COUNT-1:0] mask;
        logic [5:0]            cell_x;
        logic [5:0]            cell_y;
    } cell_entry_t;

    function automatic logic [2:0] first_face(input logic [FACE_COUNT-1:0] mask);
        logic [2:0] code;
        logic       found;
        code  = FACE_TOP;
        found = 1'b0;
        for (int i = 0; i < FACE_COUNT; i++) begin
            if (mask[i] && !found) begin
                code  = 3'(i);
                found = 1'b1;
            end
        end
        return code;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/core/sefc_front.sv
// Front end: takes pixel items, keeps two columns of opacity history and
// decides the faces of the cell one column back. Uses sefc_pkg.
`default_nettype none

module sefc_front #(
    parameter int MAX_HEIGHT = 64,
    parameter int MAX_WIDTH  = 64,
    parameter int HW         = 7
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  clear,
    input  wire logic [HW-1:0]         height,
    input  wire logic                  pixel_valid,
    output logic                       pixel_stall,
    input  wire sefc_pkg::pixel_item_t pixel,
    input  wire logic                  queue_full,
    output logic                       push,
    output sefc_pkg::cell_entry_t      entry
);
    import sefc_pkg::*;

    localparam int RW        = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int CLW       = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int ABOVE_IDX = (MAX_HEIGHT >= 2) ? MAX_HEIGHT - 2 : 0;

    // near_reg holds history[h-1 .. 0] at [M-1 .. M-h]; far_reg holds
    // history[2h-1 .. h] the same way. New bits enter at M-h, so the
    // taps we need sit at fixed positions.
    logic [MAX_HEIGHT-1:0] near_reg, near_next;
    logic [MAX_HEIGHT-1:0] far_reg, far_next;
    logic                  below_reg;          // history[h]
    logic [RW-1:0]         row_reg, row_next;
    logic [CLW-1:0]        col_reg, col_next;
    logic                  primed_reg, primed_next;

    logic                  accept;
    logic                  cur;
    logic [HW-1:0]         start;
    logic                  row_wrap;
    logic [FACE_COUNT-1:0] mask;

    assign pixel_stall = queue_full;
    assign accept      = pixel_valid && !queue_full;
    assign cur         = (pixel.kind == KIND_PIXEL) && (pixel.alpha != 8'd0);
    assign start       = HW'(MAX_HEIGHT) - height;
    assign row_wrap    = (HW'(row_reg) + HW'(1)) >= height;

    always_comb
    begin
        mask = '0;
        if (primed_reg && near_reg[MAX_HEIGHT-1]) begin
            mask[FACE_TOP]       = 1'b1;
            mask[FACE_BOTTOM]    = 1'b1;
            mask[FACE_ROW_MINUS] = (row_reg == '0) || !below_reg;
            mask[FACE_ROW_PLUS]  = row_wrap || !near_reg[ABOVE_IDX];
            mask[FACE_COL_PLUS]  = !cur;
            mask[FACE_COL_MINUS] = !far_reg[MAX_HEIGHT-1];
        end
    end

    assign push         = accept && (mask != '0);
    assign entry.mask   = mask;
    assign entry.cell_x = 6'(col_reg);
    assign entry.cell_y = 6'(row_reg);

    always_comb
    begin
        near_next = near_reg;
        far_next  = far_reg;
        for (int j = 0; j < MAX_HEIGHT; j++) begin
            if (HW'(j) == start) begin
                near_next[j] = cur;
                far_next[j]  = near_reg[MAX_HEIGHT-1];
            end else if (HW'(j) > start) begin
                near_next[j] = near_reg[j-1];
                far_next[j]  = far_reg[j-1];
            end
        end

        row_next    = row_wrap ? '0 : row_reg + RW'(1);
        col_next    = col_reg;
        primed_next = primed_reg;
        if (row_wrap) begin
            if (primed_reg) begin
                col_next = (col_reg == CLW'(MAX_WIDTH - 1)) ? '0 : col_reg + CLW'(1);
            end else begin
                primed_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            near_reg   <= '0;
            far_reg    <= '0;
            below_reg  <= 1'b0;
            row_reg    <= '0;
            col_reg    <= '0;
            primed_reg <= 1'b0;
        end else if (clear) begin
            near_reg   <= '0;
            far_reg    <= '0;
            below_reg  <= 1'b0;
            row_reg    <= '0;
            col_reg    <= '0;
            primed_reg <= 1'b0;
        end else if (accept) begin
            near_reg   <= near_next;
            far_reg    <= far_next;
            below_reg  <= near_reg[MAX_HEIGHT-1];
            row_reg    <= row_next;
            col_reg    <= col_next;
            primed_reg <= primed_next;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/sefc_queue.sv
// Two-entry queue of decided cells between front and back end.
// Uses sefc_pkg for the entry type and depth.
`default_nettype none

module sefc_queue (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  push,
    input  wire sefc_pkg::cell_entry_t push_entry,
    input  wire logic                  pop,
    output logic                       full,
    output logic                       nonempty,
    output sefc_pkg::cell_entry_t      head
);
    import sefc_pkg::*;

    localparam int PW = $clog2(QUEUE_DEPTH);
    localparam int NW = $clog2(QUEUE_DEPTH + 1);

    cell_entry_t   mem [QUEUE_DEPTH];
    logic [PW-1:0] wr_ptr_reg;
    logic [PW-1:0] rd_ptr_reg;
    logic [NW-1:0] count_reg;
    logic          do_push;
    logic          do_pop;

    assign full     = count_reg == NW'(QUEUE_DEPTH);
    assign nonempty = count_reg != '0;
    assign head     = mem[rd_ptr_reg];
    assign do_push  = push && !full;
    assign do_pop   = pop && nonempty;

    always_ff @(posedge clk)
    begin
        if (do_push) begin
            mem[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= (wr_ptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
            end
            if (do_pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + NW'(1);
            end else if (do_pop && !do_push) begin
                count_reg <= count_reg - NW'(1);
            end
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/sefc_back.sv
// Back end: walks the face mask of each queued cell and emits one face
// item per cycle while face_stall is low, through an output register. Uses sefc_pkg.
`default_nettype none

module sefc_back (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  queue_nonempty,
    input  wire sefc_pkg::cell_entry_t queue_head,
    output logic                       pop,
    output logic                       face_valid,
    input  wire logic                  face_stall,
    output sefc_pkg::face_item_t       face_item
);
    import sefc_pkg::*;

    logic                  cur_valid_reg, cur_valid_next;
    logic [FACE_COUNT-1:0] cur_mask_reg, cur_mask_next;
    logic [5:0]            cur_x_reg;
    logic [5:0]            cur_y_reg;
    logic                  out_valid_reg;
    face_item_t            out_item_reg;

    logic                  load;
    logic [FACE_COUNT-1:0] lowest;
    logic [FACE_COUNT-1:0] remaining;
    logic                  cell_done;

    assign load      = !out_valid_reg || !face_stall;
    assign lowest    = cur_mask_reg & (~cur_mask_reg + FACE_COUNT'(1));
    assign remaining = cur_mask_reg & ~lowest;
    assign cell_done = load && cur_valid_reg && (remaining == '0);
    assign pop       = queue_nonempty && (!cur_valid_reg || cell_done);

    always_comb
    begin
        cur_valid_next = cur_valid_reg;
        cur_mask_next  = cur_mask_reg;
        if (pop) begin
            cur_valid_next = 1'b1;
            cur_mask_next  = queue_head.mask;
        end else if (cell_done) begin
            cur_valid_next = 1'b0;
        end else if (load && cur_valid_reg) begin
            cur_mask_next = remaining;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            cur_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            cur_valid_reg <= cur_valid_next;
            if (load) begin
                out_valid_reg <= cur_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        cur_mask_reg <= cur_mask_next;
        if (pop) begin
            cur_x_reg <= queue_head.cell_x;
            cur_y_reg <= queue_head.cell_y;
        end
        if (load) begin
            out_item_reg.cell_x <= cur_x_reg;
            out_item_reg.cell_y <= cur_y_reg;
            out_item_reg.face   <= first_face(cur_mask_reg);
            out_item_reg.last   <= remaining == '0;
        end
    end

    assign face_valid = out_valid_reg;
    assign face_item  = out_item_reg;

endmodule

`default_nettype wire

FILE: rtl/core/sprite_extrusion_face_cull_core.sv
// Top level of the sprite extrusion face culler: APB register, front end,
// cell queue and face serializer. Uses sefc_pkg and the sefc_* modules.
`default_nettype none

// Takes sprite alpha bytes column by column and emits the visible faces of
// each opaque cell (top and bottom always, sides only toward transparent or
// out-of-image neighbors), one column behind the input. A pixel item is taken
// every cycle while the two-entry cell queue has room; a transparent cell or
// one still in the first column puts nothing in the queue. Output is set by the
// face serializer at one face per cycle while face_stall is low, so a decided
// opaque cell gives 2 to 6 faces and the sustained input rate is set by the
// number of faces per pixel, at most 6. The first face of a cell passes
// through the cell queue, the serializer's current-cell register and its
// output register. Writing image_height (clamped to 1..MAX_HEIGHT) restarts
// the image and clears the history; write it only while the block is idle.
module sprite_extrusion_face_cull_core #(
    parameter int MAX_HEIGHT = 64,
    parameter int MAX_WIDTH  = 64
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  pixel_valid,
    output logic                       pixel_stall,
    input  wire sefc_pkg::pixel_item_t pixel,
    output logic                       face_valid,
    input  wire logic                  face_stall,
    output sefc_pkg::face_item_t       face_item,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [2:0]            paddr,
    input  wire logic [31:0]           pwdata,
    output logic [31:0]                prdata,
    output logic                       pready
);
    import sefc_pkg::*;

    localparam int HW   = $clog2(MAX_HEIGHT + 1);
    localparam int CMPW = (HW > HEIGHT_FIELD_W) ? HW : HEIGHT_FIELD_W;
    localparam int HEIGHT_AT_RESET = (MAX_HEIGHT < 16) ? MAX_HEIGHT : 16;

    logic [HW-1:0]             height_reg, height_next;
    logic [HEIGHT_FIELD_W-1:0] wr_value;
    logic                      height_write;

    logic                      queue_full;
    logic                      queue_nonempty;
    logic                      push;
    logic                      pop;
    cell_entry_t               push_entry;
    cell_entry_t               queue_head;

    assign pready       = 1'b1;
    assign height_write = psel && penable && pwrite && pready
                          && (paddr[2] == 1'(REG_IMAGE_HEIGHT));
    assign wr_value     = pwdata[HEIGHT_FIELD_W-1:0];
    assign prdata       = (paddr[2] == 1'(REG_IMAGE_HEIGHT)) ? 32'(height_reg) : 32'd0;

    always_comb
    begin
        if (wr_value == '0) begin
            height_next = HW'(1);
        end else if (CMPW'(wr_value) > CMPW'(MAX_HEIGHT)) begin
            height_next = HW'(MAX_HEIGHT);
        end else begin
            height_next = HW'(wr_value);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            height_reg <= HW'(HEIGHT_AT_RESET);
        end else if (height_write) begin
            height_reg <= height_next;
        end
    end

    sefc_front #(
        .MAX_HEIGHT (MAX_HEIGHT),
        .MAX_WIDTH  (MAX_WIDTH),
        .HW         (HW)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .clear       (height_write),
        .height      (height_reg),
        .pixel_valid (pixel_valid),
        .pixel_stall (pixel_stall),
        .pixel       (pixel),
        .queue_full  (queue_full),
        .push        (push),
        .entry       (push_entry)
    );

    sefc_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .full       (queue_full),
        .nonempty   (queue_nonempty),
        .head       (queue_head)
    );

    sefc_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .queue_nonempty (queue_nonempty),
        .queue_head     (queue_head),
        .pop            (pop),
        .face_valid     (face_valid),
        .face_stall     (face_stall),
        .face_item      (face_item)
    );

endmodule

`default_nettype wire

FILE: sim/tb_sprite_extrusion_face_cull_core.sv
// Self-checking testbench for sprite_extrusion_face_cull_core: streams sprite columns,
// predicts the visible voxel faces and checks every face item in order.
// Depends on sefc_pkg and the core RTL only.
`default_nettype none

module tb_sprite_extrusion_face_cull_core;
    timeunit 1ns;
    timeprecision 1ps;

    import sefc_pkg::*;

    localparam int MAX_H         = 64;
    localparam int MAX_W         = 64;
    localparam int SETTLE_CYCLES = 16;
    localparam int STALL_LIMIT   = 2000;
    localparam int PRINT_LIMIT   = 40;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        pixel_valid = 1'b0;
    logic        pixel_stall;
    pixel_item_t pixel = '0;
    logic        face_valid;
    logic        face_stall = 1'b0;
    face_item_t  face_item;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    sprite_extrusion_face_cull_core #(
        .MAX_HEIGHT(MAX_H),
        .MAX_WIDTH (MAX_W)
    ) dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .pixel_valid(pixel_valid),
        .pixel_stall(pixel_stall),
        .pixel      (pixel),
        .face_valid (face_valid),
        .face_stall (face_stall),
        .face_item  (face_item),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    // predictor state
    logic [2*MAX_H-1:0] opaque_hist = '0;   // bit i = pixel i+1 places back
    int                 rows_per_col = 16;
    int                 cur_row = 0;
    int                 cur_col = 0;
    bit                 first_col_done = 1'b0;

    pixel_item_t pixel_queue[$];
    face_item_t  visible_faces[$];
    int          items_queued = 0;
    int          items_taken = 0;
    int          errors = 0;
    int          sender_gap_pct = 15;
    int          receiver_stall_pct = 47;
    int          quiet_cycles = 0;
    face_item_t  want;

    initial begin
        forever #5 clk = ~clk;
    end

    task automatic report_mismatch(input string msg);
        errors++;
        if (errors <= PRINT_LIMIT)
            $display("[%0t] mismatch: %s", $realtime, msg);
    endtask

    task automatic restart_image(input logic [6:0] value);
        if (value == 7'd0)
            rows_per_col = 1;
        else if (value > MAX_H)
            rows_per_col = MAX_H;
        else
            rows_per_col = value;
        opaque_hist    = '0;
        cur_row        = 0;
        cur_col        = 0;
        first_col_done = 1'b0;
    endtask

    // Decide the cell one column back, in the same row as the incoming pixel.
    task automatic cull_faces(input pixel_item_t px);
        logic       cur;
        logic [2:0] codes[$];
        face_item_t fi;
        int         h;
        int         r;
        cur = (px.kind == KIND_PIXEL) && (px.alpha != 8'd0);
        h   = rows_per_col;
        r   = cur_row;
        if (first_col_done && opaque_hist[h-1]) begin
            codes.push_back(FACE_TOP);
            codes.push_back(FACE_BOTTOM);
            if (r == 0 || !opaque_hist[h])
                codes.push_back(FACE_ROW_MINUS);
            if (r + 1 >= h)
                codes.push_back(FACE_ROW_PLUS);
            else if (!opaque_hist[h-2])
                codes.push_back(FACE_ROW_PLUS);
            if (!cur)
                codes.push_back(FACE_COL_PLUS);
            if (!opaque_hist[2*h-1])
                codes.push_back(FACE_COL_MINUS);
        end
        foreach (codes[k])
        begin
            fi.cell_x = 6'(cur_col);
            fi.cell_y = 6'(r);
            fi.face   = codes[k];
            fi.last   = (k == codes.size() - 1);
            visible_faces.push_back(fi);
        end
        opaque_hist = {opaque_hist[2*MAX_H-2:0], cur};
        r++;
        if (r >= h)
        begin
            r = 0;
            if (first_col_done)
                cur_col = (cur_col + 1) % MAX_W;
            else
                first_col_done = 1'b1;
        end
        cur_row = r;
    endtask

    // driver
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (!pixel_valid || !pixel_stall)
            begin
                if (pixel_valid)
                begin
                    cull_faces(pixel);
                    items_taken++;
                end
                if (pixel_queue.size() != 0 && $urandom_range(99) >= sender_gap_pct)
                begin
                    pixel_valid <= 1'b1;
                    pixel       <= pixel_queue.pop_front();
                end
                else
                begin
                    pixel_valid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            face_stall <= ($urandom_range(99) < receiver_stall_pct);
            if (face_valid && !face_stall)
            begin
                if (visible_faces.size() == 0)
                begin
                    report_mismatch($sformatf("unexpected face x=%0d y=%0d face=%0d",
                                              face_item.cell_x, face_item.cell_y,
                                              face_item.face));
                end
                else
                begin
                    want = visible_faces.pop_front();
                    if (face_item.cell_x !== want.cell_x)
                        report_mismatch($sformatf("cell_x %0d, want %0d",
                                                  face_item.cell_x, want.cell_x));
                    if (face_item.cell_y !== want.cell_y)
                        report_mismatch($sformatf("cell_y %0d, want %0d",
                                                  face_item.cell_y, want.cell_y));
                    if (face_item.face !== want.face)
                        report_mismatch($sformatf("face %0d, want %0d at x=%0d y=%0d",
                                                  face_item.face, want.face,
                                                  want.cell_x, want.cell_y));
                    if (face_item.last !== want.last)
                        report_mismatch($sformatf("last %0b, want %0b at x=%0d y=%0d",
                                                  face_item.last, want.last,
                                                  want.cell_x, want.cell_y));
                end
            end
        end
    end

    // watchdog: cycles without any item moved or register access
    always @(posedge clk)
    begin
        if ((pixel_valid && !pixel_stall) || (face_valid && !face_stall) || psel || !rst_n)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("watchdog expired, %0d faces still outstanding", visible_faces.size());
            $display("status: fail");
            $finish;
        end
    end

    task automatic queue_item(input logic kind, input logic [7:0] alpha);
        pixel_item_t px;
        px.kind  = kind;
        px.alpha = alpha;
        pixel_queue.push_back(px);
        items_queued++;
    endtask

    task automatic wait_drained(input int settle);
        while (items_taken != items_queued || visible_faces.size() != 0)
            @(posedge clk);
        repeat (settle) @(posedge clk);
    endtask

    task automatic write_height(input logic [31:0] value);
        wait_drained(SETTLE_CYCLES);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= 3'(4 * REG_IMAGE_HEIGHT);
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        restart_image(value[6:0]);
    endtask

    // Column c == w is the trailing flush column; a broken image drops it.
    task automatic queue_image(input int h, input int w, input int dens,
                               input bit pause_mid, input bit broken);
        int pause_col;
        pause_col = pause_mid ? $urandom_range(1, w) : -1;
        for (int c = 0; c <= w; c++)
        begin
            if (c == pause_col)
                wait_drained(0);
            if (c == w && broken)
                break;
            for (int y = 0; y < h; y++)
            begin
                if (c == w || $urandom_range(99) < 3)
                    queue_item(KIND_FLUSH, 8'($urandom));
                else if ($urandom_range(99) < dens)
                    queue_item(KIND_PIXEL, 8'($urandom_range(1, 255)));
                else
                    queue_item(KIND_PIXEL, 8'd0);
            end
        end
    endtask

    task automatic random_image();
        int          h;
        int          w;
        logic [31:0] value;
        h = ($urandom_range(9) < 7) ? $urandom_range(1, 6) : $urandom_range(7, 16);
        w = $urandom_range(1, 8);
        value = 32'(h);
        case ($urandom_range(19))
            0: value = 32'd0;                               // clamps to one row
            1: begin value = 32'($urandom_range(65, 127)); w = 1; end
            default: ;
        endcase
        if ($urandom_range(3) == 0)
            value = value | ($urandom & 32'hFFFF_FF80);
        h = (value[6:0] == 7'd0) ? 1 : (value[6:0] > MAX_H) ? MAX_H : int'(value[6:0]);
        write_height(value);
        queue_image(h, w, $urandom_range(20, 90), $urandom_range(9) < 3,
                    $urandom_range(99) < 15);
    endtask

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // reset height, first column only: nothing decided
        queue_item(KIND_PIXEL, 8'hFF);
        queue_item(KIND_PIXEL, 8'h00);

        // height 0 clamps to 1: every row is both edges
        write_height(32'hFFFF_FF80);
        queue_item(KIND_PIXEL, 8'hFF);
        queue_item(KIND_PIXEL, 8'hFF);
        queue_item(KIND_PIXEL, 8'h00);
        queue_item(KIND_PIXEL, 8'hFF);
        queue_item(KIND_FLUSH, 8'hFF);

        // three rows, flush in mid column, then a flush column
        write_height(32'd3);
        queue_item(KIND_PIXEL, 8'hFF);
        queue_item(KIND_PIXEL, 8'h00);
        queue_item(KIND_PIXEL, 8'h01);
        queue_item(KIND_PIXEL, 8'h80);
        queue_item(KIND_PIXEL, 8'hFF);
        queue_item(KIND_PIXEL, 8'hFF);
        queue_item(KIND_PIXEL, 8'h7F);
        queue_item(KIND_FLUSH, 8'h5A);
        queue_item(KIND_PIXEL, 8'h55);
        queue_item(KIND_FLUSH, 8'h00);
        queue_item(KIND_FLUSH, 8'h00);
        queue_item(KIND_FLUSH, 8'h00);

        // above the maximum clamps to full height
        write_height(32'd127);
        queue_item(KIND_PIXEL, 8'hAA);
        queue_item(KIND_PIXEL, 8'h55);
        queue_item(KIND_FLUSH, 8'h00);

        // full-height sprite, then random images
        write_height(32'd64);
        queue_image(MAX_H, 2, 60, 1'b0, 1'b0);
        while (items_queued < 230)
            random_image();

        sender_gap_pct     = 47;
        receiver_stall_pct = 15;
        write_height(32'd5);
        queue_image(5, 6, 70, 1'b1, 1'b0);
        while (items_queued < 340)
            random_image();

        sender_gap_pct     = 0;
        receiver_stall_pct = 0;
        // more columns than the column field holds: x wraps
        write_height(32'd1);
        queue_image(1, MAX_W + 2, 50, 1'b0, 1'b0);
        while (items_queued < 460)
            random_image();

        wait_drained(SETTLE_CYCLES);
        if (errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

`default_nettype wire
